// ----- rtl/bmhq_pkg.sv -----
// Package for the binary min-heap priority queue.
// Request/result types, opcode and status codes, and controller command types.
// No dependencies.
package bmhq_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // opcodes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // read address selects
  localparam logic [2:0] RD_ROOT   = 3'd0;
  localparam logic [2:0] RD_PARENT = 3'd1;
  localparam logic [2:0] RD_LAST   = 3'd2;
  localparam logic [2:0] RD_LEFT   = 3'd3;
  localparam logic [2:0] RD_RIGHT  = 3'd4;

  // write data selects (address is always the hole position)
  localparam logic [1:0] WR_HELD   = 2'd0;
  localparam logic [1:0] WR_PARENT = 2'd1;
  localparam logic [1:0] WR_CHILD  = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
  } bmhq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] min_value;
    logic [10:0]        entry_count;
  } bmhq_res_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_req;
    logic       ins_start;  // count++, hole at new last position, hold input value
    logic       lat_min;    // capture root as the extracted minimum
    logic       ex_start;   // count--, hole at root, hold last entry
    logic       lat_left;   // capture left child
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       pos_up;
    logic       pos_dn;
    logic       finish;
    logic [1:0] fin_status;
  } bmhq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_extract;
    logic full;
    logic empty;
    logic at_root;
    logic up_swap;
    logic no_left;
    logic has_right;
    logic dn_swap;
  } bmhq_stat_t;

endpackage

// ----- rtl/bmhq_dpath.sv -----
// Datapath of the min-heap queue: heap memory, hole position, held value, count.
// Depends on bmhq_pkg; driven by bmhq_ctrl through command/status structs.
module bmhq_dpath import bmhq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bmhq_req_t  in_item,
  input  bmhq_cmd_t  cmd,
  output bmhq_stat_t stat,
  output bmhq_res_t  res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = CW + 1;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  bmhq_req_t                    req_r;
  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                pos_r;
  logic signed [DATA_WIDTH-1:0] held_r;
  logic signed [DATA_WIDTH-1:0] min_r;
  logic signed [DATA_WIDTH-1:0] left_r;
  logic signed [DATA_WIDTH-1:0] rd_q;
  bmhq_res_t                    res_r;

  logic [PW-1:0]                left_idx;
  logic [PW-1:0]                left_m1;
  logic [CW-1:0]                pos_m1;
  logic [CW-1:0]                cnt_m1;
  logic [CW-1:0]                parent;
  logic [CW-1:0]                parent_m1;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;
  logic [DATA_WIDTH-1:0]        wr_data;
  logic                         pick_right;
  logic signed [DATA_WIDTH-1:0] child;
  logic [CW-1:0]                child_pos;
  logic signed [63:0]           in_ext;
  logic signed [63:0]           min_ext;
  logic [63:0]                  cnt_ext;

  assign left_idx  = {pos_r, 1'b0};
  assign left_m1   = left_idx - PW'(1);
  assign pos_m1    = pos_r - CW'(1);
  assign cnt_m1    = cnt_r - CW'(1);
  assign parent    = pos_r >> 1;
  assign parent_m1 = parent - CW'(1);

  // equal children: right child wins
  assign pick_right = stat.has_right && !(left_r < rd_q);
  assign child      = pick_right ? rd_q : left_r;
  assign child_pos  = pick_right ? left_idx[CW-1:0] + CW'(1) : left_idx[CW-1:0];

  assign in_ext  = 64'(req_r.value);
  assign min_ext = 64'(min_r);
  assign cnt_ext = 64'(cnt_r);

  assign stat.op_extract = (req_r.opcode == OP_EXTRACT);
  assign stat.full       = (cnt_r == CW'(CAPACITY));
  assign stat.empty      = (cnt_r == '0);
  assign stat.at_root    = (pos_r == CW'(1));
  assign stat.up_swap    = (held_r < rd_q);
  assign stat.no_left    = (left_idx > {1'b0, cnt_r});
  assign stat.has_right  = (left_idx < {1'b0, cnt_r});
  assign stat.dn_swap    = (held_r > child);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_PARENT: rd_addr = parent_m1[AW-1:0];
      RD_LAST:   rd_addr = cnt_m1[AW-1:0];
      RD_LEFT:   rd_addr = left_m1[AW-1:0];
      RD_RIGHT:  rd_addr = left_idx[AW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  assign wr_addr = pos_m1[AW-1:0];

  always_comb begin
    unique case (cmd.wr_sel)
      WR_HELD:   wr_data = held_r;
      WR_PARENT: wr_data = rd_q;
      WR_CHILD:  wr_data = child;
      default:   wr_data = held_r;
    endcase
  end

  // heap store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.ins_start) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.ex_start) begin
      cnt_r <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_item;
    end
    if (cmd.ins_start) begin
      pos_r  <= cnt_r + CW'(1);
      held_r <= in_ext[DATA_WIDTH-1:0];
    end else if (cmd.ex_start) begin
      pos_r  <= CW'(1);
      held_r <= rd_q;
    end else if (cmd.pos_up) begin
      pos_r <= parent;
    end else if (cmd.pos_dn) begin
      pos_r <= child_pos;
    end
    if (cmd.lat_min) begin
      min_r <= rd_q;
    end
    if (cmd.lat_left) begin
      left_r <= rd_q;
    end
    if (cmd.finish) begin
      res_r.status      <= cmd.fin_status;
      res_r.min_value   <= (cmd.fin_status == ST_EXTRACTED) ? min_ext[31:0] : '0;
      res_r.entry_count <= cnt_ext[10:0];
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// Controller of the min-heap queue: sequences sift-up and sift-down steps.
// Depends on bmhq_pkg; commands bmhq_dpath.
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  bmhq_stat_t stat,
  output bmhq_cmd_t  cmd,
  output logic       out_valid
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_UP_CHK = 4'd2;
  localparam logic [3:0] S_UP_CMP = 4'd3;
  localparam logic [3:0] S_EX_LST = 4'd4;
  localparam logic [3:0] S_EX_HLD = 4'd5;
  localparam logic [3:0] S_DN_CHK = 4'd6;
  localparam logic [3:0] S_DN_RDR = 4'd7;
  localparam logic [3:0] S_DN_CMP = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       valid_r;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op_extract) begin
          if (stat.empty) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_EMPTY;
            state_nxt      = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ROOT;
            state_nxt  = S_EX_LST;
          end
        end else if (stat.full) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.ins_start = 1'b1;
          state_nxt     = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (stat.at_root) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_HELD;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_INSERTED;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.up_swap) begin
          cmd.wr_sel = WR_PARENT;
          cmd.pos_up = 1'b1;
          state_nxt  = S_UP_CHK;
        end else begin
          cmd.wr_sel     = WR_HELD;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_INSERTED;
          state_nxt      = S_IDLE;
        end
      end
      S_EX_LST: begin
        cmd.lat_min = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_LAST;
        state_nxt   = S_EX_HLD;
      end
      S_EX_HLD: begin
        cmd.ex_start = 1'b1;
        state_nxt    = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat.no_left) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_HELD;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_EXTRACTED;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmd.lat_left = 1'b1;
        cmd.rd_en    = stat.has_right;
        cmd.rd_sel   = RD_RIGHT;
        state_nxt    = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.dn_swap) begin
          cmd.wr_sel = WR_CHILD;
          cmd.pos_dn = 1'b1;
          state_nxt  = S_DN_CHK;
        end else begin
          cmd.wr_sel     = WR_HELD;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_EXTRACTED;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.finish;
    end
  end

  assign out_valid = valid_r;

endmodule

// ----- rtl/binary_min_heap_queue_top.sv -----
// Top level of the binary min-heap priority queue.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_dpath.
//
// A request is taken on a rising edge with start high and busy low. Every
// request gives one result, shown for exactly one cycle with out_valid high;
// the receiver cannot stall it, so it must take the result in that cycle.
// Insert on a full heap is dropped (status full); extract on an empty heap
// reports empty. On equal children sift-down takes the right child.
// Timing is set by the heap memory, which has registered read data.
// Busy stays high while an insert climbs toward the root or an extract moves
// down toward a leaf; an empty/full request finishes straight from the decide
// step. For a 1024-entry heap the worst case is an extract that descends nine
// levels. A new request is taken only once busy is low again. The result
// strobe falls in the cycle after the last step, when busy is already low,
// so the next request may start then.
// The heap memory needs no clearing after reset: only written entries are read.
module binary_min_heap_queue_top import bmhq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  bmhq_req_t in_item,
  output logic      out_valid,
  output bmhq_res_t out_result
);

  bmhq_cmd_t  cmd;
  bmhq_stat_t stat;

  // sequencing of sift steps
  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // heap memory, count and hole-based sift datapath
  bmhq_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .stat    (stat),
    .res     (out_result)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for binary_min_heap_queue_top: directed table, then random requests.
// Expected results come from a behavioral heap mirror kept in this file.
// Depends on bmhq_pkg and the RTL under rtl/.
module testbench;
  import bmhq_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;
  localparam logic [31:0] BILLION = 32'd1000000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  bmhq_req_t in_item;
  logic      out_valid;
  bmhq_res_t out_result;

  binary_min_heap_queue_top #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  // ---------------------------------------------------------------------------
  // Heap mirror: 1-based array, same sift rules as the block.
  // ---------------------------------------------------------------------------
  logic signed [31:0] heap_mirror [1:CAPACITY];
  int                 heap_size;

  bmhq_res_t expected_results [$];   // one entry per accepted request, oldest first
  bmhq_res_t oldest_result;
  int        errors;
  int        cycle_count;

  // idle stretches: alternate runs of items with and without gaps
  bit        idling;
  int        stretch_left;

  // Applies one request to the mirror and returns the result the block owes.
  function automatic bmhq_res_t predict_heap_op(bmhq_req_t req);
    bmhq_res_t          res;
    int                 pos;
    int                 left;
    int                 pick;
    logic signed [31:0] tmp;
    res = '0;
    if (req.opcode == OP_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.status = ST_FULL;            // dropped, heap untouched
      end else begin
        heap_size++;
        heap_mirror[heap_size] = req.value;
        pos = heap_size;
        // climb while strictly smaller than the parent
        while (pos > 1 && heap_mirror[pos] < heap_mirror[pos / 2]) begin
          tmp = heap_mirror[pos];
          heap_mirror[pos] = heap_mirror[pos / 2];
          heap_mirror[pos / 2] = tmp;
          pos = pos / 2;
        end
        res.status = ST_INSERTED;
      end
    end else if (heap_size == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.min_value = heap_mirror[1];
      heap_mirror[1] = heap_mirror[heap_size];
      heap_size--;
      pos = 1;
      while (2 * pos <= heap_size) begin
        left = 2 * pos;
        pick = left;
        // equal children: the right one wins
        if (left + 1 <= heap_size && !(heap_mirror[left] < heap_mirror[left + 1])) begin
          pick = left + 1;
        end
        if (!(heap_mirror[pos] > heap_mirror[pick])) break;
        tmp = heap_mirror[pos];
        heap_mirror[pos] = heap_mirror[pick];
        heap_mirror[pick] = tmp;
        pos = pick;
      end
      res.status = ST_EXTRACTED;
    end
    res.entry_count = 11'(heap_size);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. known=1 rows carry a hand-written result; the rest use the
  // mirror. Covers empty extract, the signed extremes, the 1e9 value (no
  // sentinel), negative/positive ordering and duplicate keys.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic      known;
    bmhq_req_t req;
    bmhq_res_t res;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 24;

  stim_row_t directed_table [DIRECTED_ROWS] = '{
    {1'b1, OP_EXTRACT, 32'h00000000, ST_EMPTY,     32'h00000000, 11'd0},
    {1'b1, OP_INSERT,  32'h7fffffff, ST_INSERTED,  32'h00000000, 11'd1},
    {1'b1, OP_INSERT,  32'h80000000, ST_INSERTED,  32'h00000000, 11'd2},
    {1'b1, OP_EXTRACT, 32'h00000000, ST_EXTRACTED, 32'h80000000, 11'd1},
    {1'b1, OP_EXTRACT, 32'hffffffff, ST_EXTRACTED, 32'h7fffffff, 11'd0},
    {1'b1, OP_EXTRACT, 32'hffffffff, ST_EMPTY,     32'h00000000, 11'd0},
    {1'b1, OP_INSERT,  BILLION,      ST_INSERTED,  32'h00000000, 11'd1},
    {1'b1, OP_INSERT,  BILLION,      ST_INSERTED,  32'h00000000, 11'd2},
    {1'b1, OP_INSERT,  32'h00000000, ST_INSERTED,  32'h00000000, 11'd3},
    {1'b1, OP_INSERT,  32'hffffffff, ST_INSERTED,  32'h00000000, 11'd4},
    {1'b0, OP_INSERT,  32'h00000001, 45'h0},
    {1'b0, OP_INSERT,  32'h00000000, 45'h0},
    {1'b0, OP_INSERT,  32'h00000000, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0},
    {1'b1, OP_EXTRACT, 32'h00000000, ST_EMPTY,     32'h00000000, 11'd0},
    {1'b0, OP_INSERT,  32'haaaaaaaa, 45'h0},
    {1'b0, OP_INSERT,  32'h55555555, 45'h0},
    {1'b0, OP_EXTRACT, 32'h00000000, 45'h0}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case a result or a busy release never comes
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checker. The strobe lasts one cycle and cannot be stalled, so every
  // out_valid edge pops one expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: status %0d min %0d count %0d",
                 $time, out_result.status, out_result.min_value, out_result.entry_count);
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_result.status !== oldest_result.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d",
                   $time, oldest_result.status, out_result.status);
        end
        if (out_result.min_value !== oldest_result.min_value) begin
          errors++;
          $display("%0t: min_value expected %0d got %0d",
                   $time, oldest_result.min_value, out_result.min_value);
        end
        if (out_result.entry_count !== oldest_result.entry_count) begin
          errors++;
          $display("%0t: entry_count expected %0d got %0d",
                   $time, oldest_result.entry_count, out_result.entry_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Gap after the next request: inside idle stretches some requests get a random gap; outside, none.
  function automatic int next_gap();
    if (stretch_left == 0) begin
      idling = !idling;
      stretch_left = $urandom_range(10, 60);
    end
    stretch_left--;
    if (idling && $urandom_range(0, 2) == 0) return $urandom_range(1, 12);
    return 0;
  endfunction

  // Value mix: full random, a narrow band for duplicate keys, the extremes,
  // values around 1e9, and forced negatives.
  function automatic logic [31:0] heap_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 15) - 8;
      7: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fffffff;
          1:       return 32'h80000000;
          2:       return 32'h00000000;
          default: return 32'hffffffff;
        endcase
      end
      8:       return BILLION + $urandom_range(0, 2) - 1;
      default: return $urandom | 32'h80000000;
    endcase
  endfunction

  function automatic bmhq_req_t random_request(int insert_pct);
    bmhq_req_t req;
    req.opcode = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
    req.value  = heap_value();   // random on extracts too, the block ignores it
    return req;
  endfunction

  // Presents one request, waits for the accepting edge, records the expected
  // result. start stays high into the next request unless a gap follows.
  task automatic send_request(bmhq_req_t req, logic known, bmhq_res_t known_res, int gap);
    bmhq_res_t predicted;
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    predicted = predict_heap_op(req);
    expected_results.insert(expected_results.size(), known ? known_res : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result is back (start is low).
  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    heap_size    = 0;
    errors       = 0;
    idling       = 1'b0;
    stretch_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; the last one lowers start so the heap settles
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_table[i].req, directed_table[i].known, directed_table[i].res,
                   (i == DIRECTED_ROWS - 1) ? 1 : next_gap());
    end
    drain_results();

    // balanced mix around a small heap: empty extracts still show up
    for (int i = 0; i < 150; i++) begin
      send_request(random_request(50), 1'b0, '0, (i == 149) ? 1 : next_gap());
    end
    drain_results();

    // insert-heavy run up to capacity, then hammer the full boundary
    while (heap_size < CAPACITY) begin
      send_request(random_request(92), 1'b0, '0, next_gap());
    end
    for (int i = 0; i < 40; i++) begin
      send_request(random_request(75), 1'b0, '0, next_gap());
    end

    // closing stretch back to back, no idling
    for (int i = 0; i < 150; i++) begin
      send_request(random_request(50), 1'b0, '0, (i == 149) ? 1 : 0);
    end
    drain_results();
    repeat (SETTLE) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bmhq_pkg.sv
rtl/bmhq_dpath.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue_top.sv
verif/testbench.sv
